[rtl/fscs_pkg.sv]
// Shared types and constants of the fixed-step catch-up scheduler.
package fscs_pkg;

	localparam int TIME_W  = 64;
	localparam int STEP_W  = 20;
	localparam int CREDIT_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 20;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_STEP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCUM     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_NEW_PER_FRAME = 2'd2;

	// Register values after reset.
	localparam logic [STEP_W-1:0]   FIXED_STEP_RST    = 20'd16667;
	localparam logic [CREDIT_W-1:0] MAX_ACCUM_RST     = 8'd5;
	localparam logic [CREDIT_W-1:0] NEW_PER_FRAME_RST = 8'd1;

	// Input item kinds.
	localparam logic FUNC_QUERY   = 1'b0;
	localparam logic FUNC_ADVANCE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_TEST,
		ST_DIV1,
		ST_DIV2,
		ST_START3,
		ST_DIV3,
		ST_FINISH
	} state_t;

	// Divisor chosen for a division.
	typedef enum logic [1:0] {
		DSEL_FIXED,
		DSEL_BUDGET,
		DSEL_STEP
	} div_sel_t;

	// Result chosen for the pending output.
	typedef enum logic [1:0] {
		RSEL_ZERO,
		RSEL_FIXED,
		RSEL_ITERS
	} res_sel_t;

	typedef struct packed {
		logic     capture;
		logic     prep;
		logic     test;
		logic     div_start;
		div_sel_t div_sel;
		logic     step_latch;
		logic     res_load;
		res_sel_t res_sel;
		logic     budget_upd;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic func;
		logic due;
		logic div_busy;
		logic over_budget;
		logic budget_zero;
		logic out_free;
	} status_t;

endpackage

[rtl/fscs_div.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
module fscs_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fscs_pkg::TIME_W-1:0] dividend,
	input  logic [fscs_pkg::TIME_W-1:0] divisor,
	output logic                        busy,
	output logic [fscs_pkg::TIME_W-1:0] quotient,
	output logic                        rem_nz
);

	localparam int CNT_W = $clog2(fscs_pkg::TIME_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(fscs_pkg::TIME_W - 1);

	logic                          busy_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [fscs_pkg::TIME_W-1:0]   rem_q;
	logic [fscs_pkg::TIME_W-1:0]   quo_q;
	logic [fscs_pkg::TIME_W-1:0]   dvs_q;
	logic [fscs_pkg::TIME_W:0]     trial;
	logic [fscs_pkg::TIME_W+1:0]   diff;
	logic                          ge;

	assign trial = {rem_q, quo_q[fscs_pkg::TIME_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};
	assign ge    = ~diff[fscs_pkg::TIME_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[fscs_pkg::TIME_W-1:0] : trial[fscs_pkg::TIME_W-1:0];
			quo_q <= {quo_q[fscs_pkg::TIME_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;
	assign rem_nz   = (rem_q != '0);

endmodule

[rtl/fscs_dp.sv]
// Datapath: configuration, scheduler state, divider, result and output registers.
module fscs_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fscs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fscs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            func,
	input  logic [fscs_pkg::TIME_W-1:0]     now_us,
	input  logic [fscs_pkg::TIME_W-1:0]     advance_us,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [fscs_pkg::CREDIT_W-1:0]   iterations,
	output logic [fscs_pkg::TIME_W-1:0]     step_us,
	input  fscs_pkg::cmd_t                  cmd,
	output fscs_pkg::status_t               status
);

	localparam int TW = fscs_pkg::TIME_W;
	localparam int CW = fscs_pkg::CREDIT_W;
	localparam int SW = fscs_pkg::STEP_W;

	logic [SW-1:0] fixed_q;
	logic [CW-1:0] max_accum_q;
	logic [CW-1:0] npf_q;

	logic [TW-1:0] last_q;
	logic [CW-1:0] budget_q;
	logic          first_q;

	logic          func_q;
	logic [TW-1:0] now_q;
	logic [TW-1:0] adv_q;
	logic [TW-1:0] amount_q;
	logic [TW-1:0] step_q;
	logic [CW-1:0] res_iters_q;
	logic [TW-1:0] res_step_q;
	logic          out_valid_q;
	logic [CW-1:0] out_iters_q;
	logic [TW-1:0] out_step_q;

	logic [SW-1:0] fixed_eff;
	logic [TW-1:0] fixed_ext;
	logic [TW-1:0] diff_now;
	logic [TW-1:0] div_divisor;
	logic          div_busy;
	logic [TW-1:0] div_quo;
	logic          div_rem_nz;
	logic [TW-1:0] ceil_q;
	logic [CW-1:0] sel_iters;
	logic [TW-1:0] sel_step;
	logic [CW+1:0] new_budget;
	logic [CW-1:0] clamped_budget;

	// A step length of zero counts as one microsecond.
	assign fixed_eff = (fixed_q == '0) ? SW'(1) : fixed_q;
	assign fixed_ext = {{(TW-SW){1'b0}}, fixed_eff};
	assign diff_now  = now_q - last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_q     <= fscs_pkg::FIXED_STEP_RST;
			max_accum_q <= fscs_pkg::MAX_ACCUM_RST;
			npf_q       <= fscs_pkg::NEW_PER_FRAME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				fscs_pkg::CFG_FIXED_STEP:    fixed_q     <= cfg_wdata;
				fscs_pkg::CFG_MAX_ACCUM:     max_accum_q <= cfg_wdata[CW-1:0];
				fscs_pkg::CFG_NEW_PER_FRAME: npf_q       <= cfg_wdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cmd.div_sel)
			fscs_pkg::DSEL_FIXED:  div_divisor = fixed_ext;
			fscs_pkg::DSEL_BUDGET: div_divisor = {{(TW-CW){1'b0}}, budget_q};
			fscs_pkg::DSEL_STEP:   div_divisor = step_q;
			default:               div_divisor = fixed_ext;
		endcase
	end

	fscs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ((cmd.div_sel == fscs_pkg::DSEL_FIXED) ? diff_now : amount_q),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quo),
		.rem_nz   (div_rem_nz)
	);

	assign ceil_q = div_quo + {{(TW-1){1'b0}}, div_rem_nz};

	always_comb begin
		case (cmd.res_sel)
			fscs_pkg::RSEL_ZERO: begin
				sel_iters = '0;
				sel_step  = '0;
			end
			fscs_pkg::RSEL_FIXED: begin
				sel_iters = ceil_q[CW-1:0];
				sel_step  = fixed_ext;
			end
			fscs_pkg::RSEL_ITERS: begin
				sel_iters = ceil_q[CW-1:0];
				sel_step  = step_q;
			end
			default: begin
				sel_iters = '0;
				sel_step  = '0;
			end
		endcase
	end

	// The granted count never exceeds the budget, so this stays non-negative.
	assign new_budget = {2'b00, budget_q} - {2'b00, sel_iters} + {2'b00, npf_q};
	assign clamped_budget = (new_budget > {2'b00, max_accum_q}) ? max_accum_q
		: new_budget[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			budget_q <= '0;
			first_q  <= 1'b1;
		end else begin
			if (cmd.prep) begin
				if (func_q == fscs_pkg::FUNC_ADVANCE) begin
					last_q <= last_q + adv_q;
				end else if (first_q) begin
					last_q   <= now_q;
					budget_q <= max_accum_q;
					first_q  <= 1'b0;
				end
			end
			if (cmd.budget_upd) begin
				budget_q <= clamped_budget;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			now_q  <= now_us;
			adv_q  <= advance_us;
		end
		if (cmd.test) begin
			amount_q <= diff_now;
		end
		if (cmd.step_latch) begin
			step_q <= ceil_q;
		end
		if (cmd.res_load) begin
			res_iters_q <= sel_iters;
			res_step_q  <= sel_step;
		end
		if (cmd.out_load) begin
			out_iters_q <= res_iters_q;
			out_step_q  <= res_step_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		status.func        = func_q;
		status.due         = (now_q >= last_q) && (diff_now >= fixed_ext);
		status.div_busy    = div_busy;
		status.over_budget = (ceil_q[TW-1:CW] != '0) || (ceil_q[CW-1:0] > budget_q);
		status.budget_zero = (budget_q == '0);
		status.out_free    = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign iterations = out_iters_q;
	assign step_us    = out_step_q;

endmodule

[rtl/fscs_ctrl.sv]
// Controller state machine that sequences the datapath for one item.
module fscs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output fscs_pkg::cmd_t    cmd,
	input  fscs_pkg::status_t status
);

	fscs_pkg::state_t state_q;
	fscs_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fscs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.div_sel = fscs_pkg::DSEL_FIXED;
		cmd.res_sel = fscs_pkg::RSEL_ZERO;
		in_ready    = 1'b0;
		case (state_q)
			fscs_pkg::ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = fscs_pkg::ST_PREP;
				end
			end
			fscs_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				if (status.func == fscs_pkg::FUNC_ADVANCE) begin
					cmd.res_load = 1'b1;
					state_d      = fscs_pkg::ST_FINISH;
				end else begin
					state_d = fscs_pkg::ST_TEST;
				end
			end
			fscs_pkg::ST_TEST: begin
				cmd.test = 1'b1;
				if (status.due) begin
					cmd.div_start = 1'b1;
					state_d       = fscs_pkg::ST_DIV1;
				end else begin
					cmd.res_load = 1'b1;
					state_d      = fscs_pkg::ST_FINISH;
				end
			end
			fscs_pkg::ST_DIV1: begin
				if (!status.div_busy) begin
					if (!status.over_budget) begin
						cmd.res_sel    = fscs_pkg::RSEL_FIXED;
						cmd.res_load   = 1'b1;
						cmd.budget_upd = 1'b1;
						state_d        = fscs_pkg::ST_FINISH;
					end else if (status.budget_zero) begin
						cmd.res_load   = 1'b1;
						cmd.budget_upd = 1'b1;
						state_d        = fscs_pkg::ST_FINISH;
					end else begin
						cmd.div_sel   = fscs_pkg::DSEL_BUDGET;
						cmd.div_start = 1'b1;
						state_d       = fscs_pkg::ST_DIV2;
					end
				end
			end
			fscs_pkg::ST_DIV2: begin
				if (!status.div_busy) begin
					cmd.step_latch = 1'b1;
					state_d        = fscs_pkg::ST_START3;
				end
			end
			fscs_pkg::ST_START3: begin
				cmd.div_sel   = fscs_pkg::DSEL_STEP;
				cmd.div_start = 1'b1;
				state_d       = fscs_pkg::ST_DIV3;
			end
			fscs_pkg::ST_DIV3: begin
				if (!status.div_busy) begin
					cmd.res_sel    = fscs_pkg::RSEL_ITERS;
					cmd.res_load   = 1'b1;
					cmd.budget_upd = 1'b1;
					state_d        = fscs_pkg::ST_FINISH;
				end
			end
			fscs_pkg::ST_FINISH: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = fscs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fscs_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/fixed_step_catchup_scheduler_unit.sv]
// Top level of the fixed-step catch-up scheduler.
//
// An input transfer on in_valid/in_ready carries func, now_us and advance_us.
// A query (func low) answers how many fixed steps to run now (iterations) and
// how long each is (step_us); an advance (func high) moves the last-step time
// on by advance_us and answers zeros. Every input transfer yields exactly one
// output transfer on out_valid/out_ready, in order.
// An advance passes through the prepare and finish states; a query that is not
// due adds a test state; a due query that fits the credit budget adds one
// division and one whose steps must be stretched adds three. Divisions run on
// the single shared 64-bit divider, which yields one quotient bit per cycle and
// is used up to three times per query. One item is processed at a time;
// in_ready is high only while the controller is idle, so the next transfer can
// be accepted in the same cycle as the result is offered.
// The result sits in an output register, so a new item may be accepted while
// the previous result still waits for the receiver. A stalled receiver holds
// the output steady; the next result is held back until it has been taken.
// The configuration port writes a register whenever cfg_we is high; it must
// only be used while no item is in flight. Reset restores the register
// defaults, clears the last-step time and budget and arms the first query.
module fixed_step_catchup_scheduler_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fscs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fscs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            func,
	input  logic [fscs_pkg::TIME_W-1:0]     now_us,
	input  logic [fscs_pkg::TIME_W-1:0]     advance_us,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [fscs_pkg::CREDIT_W-1:0]   iterations,
	output logic [fscs_pkg::TIME_W-1:0]     step_us
);

	fscs_pkg::cmd_t    cmd;
	fscs_pkg::status_t status;

	// The controller decides what happens in each cycle; the datapath holds
	// all of the numbers.
	fscs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.status   (status)
	);

	fscs_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.func       (func),
		.now_us     (now_us),
		.advance_us (advance_us),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.iterations (iterations),
		.step_us    (step_us),
		.cmd        (cmd),
		.status     (status)
	);

`ifndef SYNTHESIS
	// The divider is never restarted while it is still working.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !status.div_busy)
		else $error("divider started while busy");

	// A new result never overwrites one the receiver has not yet taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid || out_ready))
		else $error("output register overwritten");

	// A granted frame has both a count and a length; otherwise both are zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((iterations == '0) == (step_us == '0)))
		else $error("iterations and step length disagree");

	// Items are only taken once the divider has finished with the last one.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !status.div_busy)
		else $error("item accepted while dividing");
`endif

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the fixed-step catch-up scheduler unit.
module tb_top;

	import fscs_pkg::*;

	// The port has room for a fourth register index that selects nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// Cycles without any transfer on either side before the run is abandoned.
	// It covers the slowest item, a query with three divisions, plus the longest
	// sender gap and receiver stall, and still leaves a wide margin.
	localparam int QUIET_LIMIT = 3000;

	localparam int ITEMS_PER_PHASE = 180;
	localparam int RANDOM_PHASES   = 8;

	// One answer of the scheduler: how many steps to run and how long each is.
	typedef struct {
		bit [CREDIT_W-1:0] iters;
		bit [TIME_W-1:0]   step;
	} grant_t;

	// Tracks the scheduler's state and the answers still owed by the block.
	class catchup_tracker;
		bit [STEP_W-1:0]   step_reg;
		bit [CREDIT_W-1:0] ceiling_reg;
		bit [CREDIT_W-1:0] refill_reg;
		bit [TIME_W-1:0]   last_time;
		bit [CREDIT_W-1:0] credits;
		bit                awaiting_first;
		grant_t            owed_grants[$];
		int                errors;

		function new();
			step_reg       = FIXED_STEP_RST;
			ceiling_reg    = MAX_ACCUM_RST;
			refill_reg     = NEW_PER_FRAME_RST;
			last_time      = '0;
			credits        = '0;
			awaiting_first = 1'b1;
			errors         = 0;
		endfunction

		// A step length of zero behaves as one microsecond.
		function bit [TIME_W-1:0] nominal_step();
			return (step_reg == '0) ? 64'd1 : 64'(step_reg);
		endfunction

		function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_FIXED_STEP:    step_reg    = data[STEP_W-1:0];
				CFG_MAX_ACCUM:     ceiling_reg = data[CREDIT_W-1:0];
				CFG_NEW_PER_FRAME: refill_reg  = data[CREDIT_W-1:0];
				default: ;
			endcase
		endfunction

		function bit [TIME_W-1:0] div_ceil(bit [TIME_W-1:0] n, bit [TIME_W-1:0] d);
			return n / d + 64'((n % d) != '0);
		endfunction

		// Works out the answer to one accepted item and queues it.
		function grant_t note_item(bit is_adv, bit [TIME_W-1:0] now, bit [TIME_W-1:0] adv);
			grant_t          g;
			bit [TIME_W-1:0] nom;
			bit [TIME_W-1:0] owed;
			bit [TIME_W-1:0] n_iters;
			bit [TIME_W-1:0] len;
			bit [TIME_W-1:0] budget;
			bit [TIME_W-1:0] refilled;
			g.iters = '0;
			g.step  = '0;
			if (is_adv == FUNC_ADVANCE) begin
				last_time += adv;
			end else begin
				nom = nominal_step();
				if (awaiting_first) begin
					last_time      = now;
					credits        = ceiling_reg;
					awaiting_first = 1'b0;
				end
				if (now >= last_time && now - last_time >= nom) begin
					owed    = now - last_time;
					budget  = 64'(credits);
					n_iters = div_ceil(owed, nom);
					len     = nom;
					if (n_iters > budget) begin
						if (budget == '0) begin
							n_iters = '0;
							len     = '0;
						end else begin
							len     = div_ceil(owed, budget);
							n_iters = div_ceil(owed, len);
						end
					end
					refilled = budget - n_iters + 64'(refill_reg);
					if (refilled > 64'(ceiling_reg))
						refilled = 64'(ceiling_reg);
					credits = refilled[CREDIT_W-1:0];
					g.iters = n_iters[CREDIT_W-1:0];
					g.step  = len;
				end
			end
			owed_grants.push_back(g);
			return g;
		endfunction

		function void check_grant(logic [CREDIT_W-1:0] iters, logic [TIME_W-1:0] step);
			grant_t g;
			if (owed_grants.size() == 0) begin
				$display("%0t: result with none expected, iterations %0d step_us %0d",
					$time, iters, step);
				errors++;
				return;
			end
			g = owed_grants.pop_front();
			if (iters !== g.iters) begin
				$display("%0t: iterations expected %0d got %0d", $time, g.iters, iters);
				errors++;
			end
			if (step !== g.step) begin
				$display("%0t: step_us expected %0d got %0d", $time, g.step, step);
				errors++;
			end
		endfunction
	endclass

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index  = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic                  func       = FUNC_QUERY;
	logic [TIME_W-1:0]     now_us     = '0;
	logic [TIME_W-1:0]     advance_us = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic [CREDIT_W-1:0]   iterations;
	logic [TIME_W-1:0]     step_us;

	catchup_tracker tracker = new();

	// When set, neither side inserts gaps, so that back-to-back transfers occur.
	bit no_idle     = 1'b0;
	int stall_left  = 0;
	int ready_gap   = 0;
	int quiet_count = 0;

	fixed_step_catchup_scheduler_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.now_us     (now_us),
		.advance_us (advance_us),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.iterations (iterations),
		.step_us    (step_us)
	);

	always #5 clk = ~clk;

	// Gap lengths: mostly none, often short, now and then a long pause.
	function automatic int gap_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Receiving side. Outputs are sampled at the edge, before the block's own
	// updates for that edge land, so a transfer is seen exactly when it happens.
	// Ready is then lowered for a random stretch or kept high.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			tracker.check_grant(iterations, step_us);
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else begin
			ready_gap = gap_len();
			if (ready_gap != 0) begin
				stall_left <= ready_gap - 1;
				out_ready  <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: any transfer on either side restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_count <= 0;
		end else if (quiet_count >= QUIET_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end else begin
			quiet_count <= quiet_count + 1;
		end
	end

	// Offers one item and holds it until the transfer. Valid is lowered only
	// when a gap follows, so back-to-back items keep it high throughout.
	task automatic send_item(input bit is_adv, input bit [TIME_W-1:0] now,
			input bit [TIME_W-1:0] adv, output grant_t g);
		int gap;
		in_valid   <= 1'b1;
		func       <= is_adv;
		now_us     <= now;
		advance_us <= adv;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		g   = tracker.note_item(is_adv, now, adv);
		gap = gap_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic query(input bit [TIME_W-1:0] now);
		grant_t g;
		send_item(FUNC_QUERY, now, {$urandom, $urandom}, g);
	endtask

	task automatic advance(input bit [TIME_W-1:0] adv);
		grant_t g;
		send_item(FUNC_ADVANCE, {$urandom, $urandom}, adv, g);
	endtask

	// Waits until every owed answer has come back and the block has settled,
	// so that the registers may be rewritten safely.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (tracker.owed_grants.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// The write enable stays high across a run of writes and is lowered once.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
	endtask

	task automatic close_writes();
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Writes all three registers. The narrow ones get random upper bits, which
	// the block must discard.
	task automatic set_regs(input logic [STEP_W-1:0] fv, input logic [CREDIT_W-1:0] mv,
			input logic [CREDIT_W-1:0] nv);
		logic [CFG_DATA_W-1:0] d;
		write_reg(CFG_FIXED_STEP, fv);
		d = CFG_DATA_W'($urandom);
		d[CREDIT_W-1:0] = mv;
		write_reg(CFG_MAX_ACCUM, d);
		d = CFG_DATA_W'($urandom);
		d[CREDIT_W-1:0] = nv;
		write_reg(CFG_NEW_PER_FRAME, d);
		close_writes();
	endtask

	initial begin
		grant_t              g;
		grant_t              scratch;
		bit [TIME_W-1:0]     nom;
		bit [TIME_W-1:0]     delta;
		bit [TIME_W-1:0]     catch_up;
		logic [STEP_W-1:0]   fv;
		logic [CREDIT_W-1:0] mv;
		logic [CREDIT_W-1:0] nv;
		int                  k;
		int                  r;
		int                  pick;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part with the reset values of the registers. An advance before
		// the first query moves the last-step time, but the first query then
		// overrides it and loads the budget.
		advance(64'd5);
		query(64'd0);
		query(64'd16666);
		query(64'd16667);
		query(tracker.last_time + 64'd50002);
		// Far more steps owed than the budget holds, so the steps are stretched.
		query(tracker.last_time + 64'd16667 * 64'd40);
		// A time before the last step is never due, even though the difference
		// would wrap to a large value.
		query(tracker.last_time - 64'd1);
		// Advancing by all ones and then by one wraps the last-step time round.
		advance('1);
		query(64'd0);
		query('1);
		advance(64'd1);
		query('1);
		advance(64'd0);
		drain_results();

		// A zero ceiling drains the budget; the next due query finds it empty.
		set_regs(FIXED_STEP_RST, 8'd0, 8'd0);
		query(tracker.last_time + 64'd20000);
		query(tracker.last_time + 64'd40000);
		query(tracker.last_time + 64'd40000);
		drain_results();

		// A zero step length acts as one microsecond; the largest ceiling and
		// refill bring the budget back after it was empty.
		set_regs('0, 8'd255, 8'd255);
		query(tracker.last_time + 64'd1);
		query(tracker.last_time + 64'd300);
		query(tracker.last_time + 64'd255);
		drain_results();

		// A write to the unused index must leave every register as it was.
		write_reg(CFG_UNUSED, '1);
		close_writes();
		query(tracker.last_time + 64'd7);
		drain_results();

		// Random phases, each under its own register setting. The first two
		// together lower the ceiling below a full budget, which the next update
		// must clamp.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: begin
					fv = 20'd1;
					mv = 8'd255;
					nv = 8'd255;
				end
				1: begin
					fv = 20'd1000000;
					mv = 8'd1;
					nv = 8'd1;
				end
				3: begin
					fv = '1;
					mv = 8'd255;
					nv = 8'd1;
				end
				4: begin
					fv = STEP_W'($urandom_range(1, 5000));
					mv = 8'd3;
					nv = CREDIT_W'($urandom_range(1, 8));
				end
				5: begin
					fv = STEP_W'($urandom_range(1, 100));
					mv = CREDIT_W'($urandom_range(1, 16));
					nv = CREDIT_W'($urandom_range(1, 4));
				end
				6: begin
					fv = FIXED_STEP_RST;
					mv = MAX_ACCUM_RST;
					nv = NEW_PER_FRAME_RST;
				end
				default: begin
					fv = STEP_W'($urandom_range(1, 1000000));
					mv = CREDIT_W'($urandom_range(1, 255));
					nv = CREDIT_W'($urandom_range(1, 255));
				end
			endcase
			set_regs(fv, mv, nv);
			no_idle = 1'b0;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 49) == 0)
					no_idle = !no_idle;
				nom = tracker.nominal_step();
				r   = $urandom_range(0, 99);
				if (r < 72) begin
					// Frame loop as a host would run it: query at a time that owes
					// a plausible number of steps, then mostly advance the
					// last-step time by what was granted.
					pick = $urandom_range(0, 9);
					if (pick < 2)
						k = 0;
					else if (pick < 9)
						k = $urandom_range(1, tracker.ceiling_reg + 4);
					else
						k = $urandom_range(1, 5000);
					if (k == 0)
						delta = 64'($urandom_range(0, nom[31:0] - 1));
					else
						delta = nom * 64'(k) - 64'($urandom_range(0, nom[31:0] - 1));
					send_item(FUNC_QUERY, tracker.last_time + delta, {$urandom, $urandom}, g);
					if (g.iters != '0 && $urandom_range(0, 3) != 0) begin
						catch_up = 64'(g.iters) * g.step;
						send_item(FUNC_ADVANCE, {$urandom, $urandom}, catch_up, scratch);
					end
				end else if (r < 82) begin
					advance(64'($urandom_range(0, 2 * nom[31:0])));
				end else if (r < 90) begin
					query({$urandom, $urandom});
				end else if (r < 95) begin
					advance({$urandom, $urandom});
				end else begin
					query(tracker.last_time - 64'($urandom_range(1, 1000)));
				end
			end
			drain_results();
		end

		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.owed_grants.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
